>>> design/d2aw_pkg.sv
package d2aw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ALPHA_W   = FRAC_BITS + 1;
    localparam logic [ALPHA_W-1:0] ONE_Q = ALPHA_W'(1) << FRAC_BITS;

    localparam int DIV_NUM_W = 114;
    localparam int DIV_DEN_W = 81;
    localparam int DIV_Q_W   = 64;
    localparam int DIV_CNT_W = 7;

    localparam int EXP_STEPS = 30;
    localparam int COEF_W    = 31;

    localparam logic [1:0] CFG_SEGMENT_SIZE = 2'd0;
    localparam logic [1:0] CFG_GAIN_G       = 2'd1;
    localparam logic [1:0] CFG_ALPHA_INIT   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CW_MUL,
        ST_CW_USE,
        ST_BY_MUL,
        ST_BY_USE,
        ST_FRAC_WAIT,
        ST_EW1_MUL,
        ST_EW2_MUL,
        ST_EW_SUM,
        ST_DEN_MUL,
        ST_NUM_MUL,
        ST_PQ_WAIT,
        ST_LOG_MUL,
        ST_LOG_USE,
        ST_E_MUL,
        ST_EXP_MUL,
        ST_EXP_USE,
        ST_FINAL,
        ST_CLEAR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] len;
    } div_cmd_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [EXP_STEPS*COEF_W-1:0] exp_coef_table();
        logic [63:0]                  c;
        logic [EXP_STEPS*COEF_W-1:0]  t;
        c = 64'd1 << 29;
        t = '0;
        for (int i = 0; i < EXP_STEPS; i++) begin
            t[i*COEF_W +: COEF_W] = c[COEF_W-1:0];
            c = isqrt64(c << 30);
        end
        return t;
    endfunction

    localparam logic [EXP_STEPS*COEF_W-1:0] EXP_COEF = exp_coef_table();

endpackage

>>> design/d2aw_div.sv
module d2aw_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  d2aw_pkg::div_cmd_t                  cmd,
    input  logic [d2aw_pkg::DIV_NUM_W-1:0]      num,
    input  logic [d2aw_pkg::DIV_DEN_W-1:0]      den,
    output logic [d2aw_pkg::DIV_Q_W-1:0]        quot,
    output d2aw_pkg::div_stat_t                 stat
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic                               ovf_reg, ovf_next;
    logic [d2aw_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [d2aw_pkg::DIV_NUM_W-1:0]     numsh_reg, numsh_next;
    logic [d2aw_pkg::DIV_DEN_W-1:0]     den_reg, den_next;
    logic [d2aw_pkg::DIV_DEN_W-1:0]     rem_reg, rem_next;
    logic [d2aw_pkg::DIV_Q_W-1:0]       q_reg, q_next;
    logic [d2aw_pkg::DIV_DEN_W:0]       trial;
    logic                               ge;

    assign trial = {rem_reg, numsh_reg[d2aw_pkg::DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        numsh_next = numsh_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        if (cmd.start) begin
            busy_next  = 1'b1;
            ovf_next   = 1'b0;
            cnt_next   = cmd.len;
            numsh_next = num;
            den_next   = den;
            rem_next   = '0;
            q_next     = '0;
        end else if (busy_reg) begin
            rem_next   = ge ? d2aw_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                            : trial[d2aw_pkg::DIV_DEN_W-1:0];
            q_next     = {q_reg[d2aw_pkg::DIV_Q_W-2:0], ge};
            ovf_next   = ovf_reg | q_reg[d2aw_pkg::DIV_Q_W-1];
            numsh_next = numsh_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == d2aw_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg   <= ovf_next;
        numsh_reg <= numsh_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
    end

    assign quot      = q_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

>>> design/d2tcp_alpha_window_update_top.sv
// Channel   | Direction | Transfer when      | Payload
// s_        | in        | s_valid & s_ready  | kind, segments_acked, ece_received, seqs, times, cwnd
// m_        | out       | m_valid & m_ready  | alpha, window_closed, new_cwnd
// cfg_      | in        | cfg_wr_en          | cfg_index, cfg_data
// One item at a time; s_ready is high only between items.
// Reduce event and ack without window close: a multiply state and a use state, then ST_OUT.
// Window close: the 48-step serial divide for the marked fraction sets its length.
// Window close with deadline penalty: length set by the 35-step shift-add multiplier
// (three passes), the 114-step serial divider and the 30-step log and exp loops
// on the shared 32x32 multiplier.
// Reset is synchronous; m_valid holds until m_ready.
module d2tcp_alpha_window_update_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [15:0]        s_segments_acked,
    input  logic               s_ece_received,
    input  logic [31:0]        s_next_tx_seq,
    input  logic [31:0]        s_last_acked_seq,
    input  logic [31:0]        s_tx_total,
    input  logic signed [47:0] s_remain_time,
    input  logic [47:0]        s_last_rtt,
    input  logic [31:0]        s_cwnd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [16:0]        m_alpha,
    output logic               m_window_closed,
    output logic [31:0]        m_new_cwnd,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam logic [16:0] ONE = d2aw_pkg::ONE_Q;

    d2aw_pkg::state_t state_reg, state_next;

    logic [15:0] segs_reg, segs_next;
    logic        ece_reg, ece_next;
    logic [31:0] ntx_reg, ntx_next;
    logic [31:0] lack_reg, lack_next;
    logic [31:0] txt_reg, txt_next;
    logic [47:0] rtime_reg, rtime_next;
    logic [47:0] rtt_reg, rtt_next;
    logic [31:0] cwnd_reg, cwnd_next;

    logic [15:0] seg_reg, seg_next;
    logic [16:0] gain_reg, gain_next;
    logic [16:0] alpha_reg, alpha_next;
    logic [31:0] marked_reg, marked_next;
    logic [31:0] wb_reg, wb_next;
    logic [31:0] wend_reg, wend_next;
    logic        armed_reg, armed_next;

    logic [63:0] prod_reg, prod_next;
    logic [33:0] t1_reg, t1_next;
    logic [16:0] frac_reg, frac_next;
    logic        pen_reg, pen_next;
    logic        closed_reg, closed_next;
    logic [31:0] ncwnd_reg, ncwnd_next;
    logic [98:0] acc_reg, acc_next;
    logic [98:0] mc_reg, mc_next;
    logic [34:0] mp_reg, mp_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [80:0] den_reg, den_next;
    logic [63:0] pq_reg, pq_next;
    logic [30:0] y_reg, y_next;
    logic [29:0] lfrac_reg, lfrac_next;
    logic [3:0]  m_reg, m_next;
    logic [4:0]  k_reg, k_next;
    logic [29:0] f_reg, f_next;
    logic [30:0] r_reg, r_next;
    logic [5:0]  nsh_reg, nsh_next;
    logic        big_reg, big_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [98:0] acc_step;

    logic [31:0] bytes;
    logic [32:0] wb_sum, mk_sum;
    logic [31:0] wb_new, mk_new, wend_eff, seq_diff;
    logic        close;
    logic [16:0] g_eff;
    logic [34:0] ew_sum;
    logic [31:0] cw_eff;
    logic [33:0] cw3;
    logic [31:0] rem_b;
    logic [63:0] pq_w;
    logic [3:0]  m_w;
    logic [31:0] sq;
    logic [29:0] lfrac_new;
    logic [34:0] lq_w;
    logic [36:0] n_w;
    logic [6:0]  sh;
    logic [30:0] shifted;
    logic [31:0] val;
    logic [30:0] coef;

    d2aw_pkg::div_cmd_t                div_cmd;
    d2aw_pkg::div_stat_t               div_stat;
    logic [d2aw_pkg::DIV_NUM_W-1:0]    div_num;
    logic [d2aw_pkg::DIV_DEN_W-1:0]    div_den;
    logic [d2aw_pkg::DIV_Q_W-1:0]      div_q;

    d2aw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_q),
        .stat    (div_stat)
    );

    assign mul_p    = mul_a * mul_b;
    assign acc_step = mp_reg[0] ? acc_reg + mc_reg : acc_reg;

    assign bytes    = prod_reg[31:0];
    assign wb_sum   = {1'b0, wb_reg} + {1'b0, bytes};
    assign mk_sum   = {1'b0, marked_reg} + {1'b0, bytes};
    assign wb_new   = wb_sum[32] ? '1 : wb_sum[31:0];
    assign mk_new   = ece_reg ? (mk_sum[32] ? '1 : mk_sum[31:0]) : marked_reg;
    assign wend_eff = armed_reg ? wend_reg : ntx_reg;
    assign seq_diff = lack_reg - wend_eff;
    assign close    = !seq_diff[31];

    assign g_eff    = (gain_reg > ONE) ? ONE : gain_reg;
    assign ew_sum   = {1'b0, t1_reg} + {1'b0, prod_reg[33:0]} + 35'd32768;
    assign cw_eff   = (cwnd_reg == '0) ? 32'd1 : cwnd_reg;
    assign cw3      = {2'b0, cw_eff} + {1'b0, cw_eff, 1'b0};
    assign rem_b    = (txt_reg > wb_reg) ? txt_reg - wb_reg : '0;
    assign pq_w     = div_stat.ovf ? '1 : div_q;

    always_comb begin
        m_w = '0;
        for (int i = 0; i < 16; i++) begin
            if (alpha_reg[i]) m_w = 4'(i);
        end
    end

    assign sq        = prod_reg[61:30];
    assign lfrac_new = sq[31] ? (lfrac_reg | (30'd1 << k_reg)) : lfrac_reg;
    assign lq_w      = {5'd16 - {1'b0, m_reg}, 30'b0} - {5'b0, lfrac_new};
    assign n_w       = acc_reg[98:62];
    assign sh        = {1'b0, nsh_reg} + 7'd14;
    assign shifted   = r_reg >> sh;
    assign val       = prod_reg[48:17];
    assign coef      = d2aw_pkg::EXP_COEF[10'(k_reg) * 10'd31 +: d2aw_pkg::COEF_W];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            d2aw_pkg::ST_IDLE:      if (s_valid) state_next = s_kind ? d2aw_pkg::ST_CW_MUL
                                                                     : d2aw_pkg::ST_BY_MUL;
            d2aw_pkg::ST_CW_MUL:    state_next = d2aw_pkg::ST_CW_USE;
            d2aw_pkg::ST_CW_USE:    state_next = d2aw_pkg::ST_OUT;
            d2aw_pkg::ST_BY_MUL:    state_next = d2aw_pkg::ST_BY_USE;
            d2aw_pkg::ST_BY_USE:    state_next = close ? d2aw_pkg::ST_FRAC_WAIT
                                                       : d2aw_pkg::ST_OUT;
            d2aw_pkg::ST_FRAC_WAIT: if (div_stat.done) state_next = d2aw_pkg::ST_EW1_MUL;
            d2aw_pkg::ST_EW1_MUL:   state_next = d2aw_pkg::ST_EW2_MUL;
            d2aw_pkg::ST_EW2_MUL:   state_next = d2aw_pkg::ST_EW_SUM;
            d2aw_pkg::ST_EW_SUM:    state_next = pen_reg ? d2aw_pkg::ST_DEN_MUL
                                                         : d2aw_pkg::ST_CLEAR;
            d2aw_pkg::ST_DEN_MUL:   if (cnt_reg == '0) state_next = d2aw_pkg::ST_NUM_MUL;
            d2aw_pkg::ST_NUM_MUL:   if (cnt_reg == '0) state_next = d2aw_pkg::ST_PQ_WAIT;
            d2aw_pkg::ST_PQ_WAIT: begin
                if (div_stat.done) begin
                    if (alpha_reg >= ONE || alpha_reg == '0) begin
                        state_next = d2aw_pkg::ST_CLEAR;
                    end else begin
                        state_next = d2aw_pkg::ST_LOG_MUL;
                    end
                end
            end
            d2aw_pkg::ST_LOG_MUL:   state_next = d2aw_pkg::ST_LOG_USE;
            d2aw_pkg::ST_LOG_USE:   state_next = (k_reg == '0) ? d2aw_pkg::ST_E_MUL
                                                               : d2aw_pkg::ST_LOG_MUL;
            d2aw_pkg::ST_E_MUL:     if (cnt_reg == '0) state_next = d2aw_pkg::ST_EXP_MUL;
            d2aw_pkg::ST_EXP_MUL:   state_next = d2aw_pkg::ST_EXP_USE;
            d2aw_pkg::ST_EXP_USE:   state_next = (k_reg == 5'd29) ? d2aw_pkg::ST_FINAL
                                                                  : d2aw_pkg::ST_EXP_MUL;
            d2aw_pkg::ST_FINAL:     state_next = d2aw_pkg::ST_CLEAR;
            d2aw_pkg::ST_CLEAR:     state_next = d2aw_pkg::ST_OUT;
            d2aw_pkg::ST_OUT:       if (m_ready) state_next = d2aw_pkg::ST_IDLE;
            default:                state_next = d2aw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == d2aw_pkg::ST_IDLE);
        m_valid = (state_reg == d2aw_pkg::ST_OUT);
    end

    always_comb begin
        segs_next   = segs_reg;
        ece_next    = ece_reg;
        ntx_next    = ntx_reg;
        lack_next   = lack_reg;
        txt_next    = txt_reg;
        rtime_next  = rtime_reg;
        rtt_next    = rtt_reg;
        cwnd_next   = cwnd_reg;
        seg_next    = seg_reg;
        gain_next   = gain_reg;
        alpha_next  = alpha_reg;
        marked_next = marked_reg;
        wb_next     = wb_reg;
        wend_next   = wend_reg;
        armed_next  = armed_reg;
        prod_next   = prod_reg;
        t1_next     = t1_reg;
        frac_next   = frac_reg;
        pen_next    = pen_reg;
        closed_next = closed_reg;
        ncwnd_next  = ncwnd_reg;
        acc_next    = acc_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        cnt_next    = cnt_reg;
        den_next    = den_reg;
        pq_next     = pq_reg;
        y_next      = y_reg;
        lfrac_next  = lfrac_reg;
        m_next      = m_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        r_next      = r_reg;
        nsh_next    = nsh_reg;
        big_next    = big_reg;
        mul_a       = '0;
        mul_b       = '0;
        div_cmd     = '0;
        div_num     = '0;
        div_den     = '0;

        unique case (state_reg)
            d2aw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    segs_next  = s_segments_acked;
                    ece_next   = s_ece_received;
                    ntx_next   = s_next_tx_seq;
                    lack_next  = s_last_acked_seq;
                    txt_next   = s_tx_total;
                    rtime_next = s_remain_time;
                    rtt_next   = s_last_rtt;
                    cwnd_next  = s_cwnd;
                end
            end
            d2aw_pkg::ST_CW_MUL: begin
                mul_a     = cwnd_reg;
                mul_b     = {14'b0, 18'h20000 - {1'b0, alpha_reg}};
                prod_next = mul_p;
            end
            d2aw_pkg::ST_CW_USE: begin
                ncwnd_next  = (val > {16'b0, seg_reg}) ? val : {16'b0, seg_reg};
                closed_next = 1'b0;
            end
            d2aw_pkg::ST_BY_MUL: begin
                mul_a     = {16'b0, segs_reg};
                mul_b     = {16'b0, seg_reg};
                prod_next = mul_p;
            end
            d2aw_pkg::ST_BY_USE: begin
                wb_next     = wb_new;
                marked_next = mk_new;
                wend_next   = wend_eff;
                armed_next  = 1'b1;
                closed_next = close;
                ncwnd_next  = cwnd_reg;
                pen_next    = !rtime_reg[47] && rtime_reg != '0 && txt_reg != '0
                              && rtt_reg != '0;
                if (close) begin
                    div_cmd.start = 1'b1;
                    div_cmd.len   = d2aw_pkg::DIV_CNT_W'(48);
                    div_num       = {mk_new, 16'b0, 66'b0};
                    div_den       = {49'b0, wb_new};
                end
            end
            d2aw_pkg::ST_FRAC_WAIT: begin
                if (div_stat.done) begin
                    if (wb_reg == '0) begin
                        frac_next = '0;
                    end else begin
                        frac_next = (div_q > {47'b0, ONE}) ? ONE : div_q[16:0];
                    end
                end
            end
            d2aw_pkg::ST_EW1_MUL: begin
                mul_a     = {15'b0, ONE - g_eff};
                mul_b     = {15'b0, alpha_reg};
                prod_next = mul_p;
            end
            d2aw_pkg::ST_EW2_MUL: begin
                t1_next   = prod_reg[33:0];
                mul_a     = {15'b0, g_eff};
                mul_b     = {15'b0, frac_reg};
                prod_next = mul_p;
            end
            d2aw_pkg::ST_EW_SUM: begin
                alpha_next = ew_sum[32:16];
                acc_next   = '0;
                mc_next    = {52'b0, rtime_reg[46:0]};
                mp_next    = {1'b0, cw3};
                cnt_next   = 6'd35;
            end
            d2aw_pkg::ST_DEN_MUL: begin
                if (cnt_reg != '0) begin
                    acc_next = acc_step;
                    mc_next  = mc_reg << 1;
                    mp_next  = mp_reg >> 1;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    den_next = acc_reg[80:0];
                    acc_next = '0;
                    mc_next  = {51'b0, rtt_reg};
                    mp_next  = {1'b0, rem_b, 2'b0};
                    cnt_next = 6'd35;
                end
            end
            d2aw_pkg::ST_NUM_MUL: begin
                if (cnt_reg != '0) begin
                    acc_next = acc_step;
                    mc_next  = mc_reg << 1;
                    mp_next  = mp_reg >> 1;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    div_cmd.start = 1'b1;
                    div_cmd.len   = d2aw_pkg::DIV_CNT_W'(d2aw_pkg::DIV_NUM_W);
                    div_num       = {acc_reg[81:0], 32'b0};
                    div_den       = den_reg;
                end
            end
            d2aw_pkg::ST_PQ_WAIT: begin
                if (div_stat.done) begin
                    pq_next = pq_w;
                    if (alpha_reg == '0) begin
                        alpha_next = (pq_w == '0) ? ONE : '0;
                    end
                    m_next     = m_w;
                    y_next     = 31'({15'b0, alpha_reg[15:0]} << (5'd30 - {1'b0, m_w}));
                    k_next     = 5'd29;
                    lfrac_next = '0;
                end
            end
            d2aw_pkg::ST_LOG_MUL: begin
                mul_a     = {1'b0, y_reg};
                mul_b     = {1'b0, y_reg};
                prod_next = mul_p;
            end
            d2aw_pkg::ST_LOG_USE: begin
                y_next     = sq[31] ? sq[31:1] : sq[30:0];
                lfrac_next = lfrac_new;
                if (k_reg == '0) begin
                    acc_next = '0;
                    mc_next  = {35'b0, pq_reg};
                    mp_next  = lq_w;
                    cnt_next = 6'd35;
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            d2aw_pkg::ST_E_MUL: begin
                if (cnt_reg != '0) begin
                    acc_next = acc_step;
                    mc_next  = mc_reg << 1;
                    mp_next  = mp_reg >> 1;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    f_next   = acc_reg[61:32];
                    big_next = n_w > 37'd49;
                    nsh_next = n_w[5:0];
                    r_next   = 31'h4000_0000;
                    k_next   = '0;
                end
            end
            d2aw_pkg::ST_EXP_MUL: begin
                mul_a     = {1'b0, r_reg};
                mul_b     = {1'b0, coef};
                prod_next = mul_p;
            end
            d2aw_pkg::ST_EXP_USE: begin
                if (f_reg[29]) r_next = prod_reg[60:30];
                f_next = f_reg << 1;
                k_next = k_reg + 1'b1;
            end
            d2aw_pkg::ST_FINAL: begin
                alpha_next = big_reg ? '0 : shifted[16:0];
            end
            d2aw_pkg::ST_CLEAR: begin
                marked_next = '0;
                wb_next     = '0;
                wend_next   = ntx_reg;
            end
            d2aw_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                d2aw_pkg::CFG_SEGMENT_SIZE: seg_next   = cfg_data[15:0];
                d2aw_pkg::CFG_GAIN_G:       gain_next  = cfg_data;
                d2aw_pkg::CFG_ALPHA_INIT:   alpha_next = (cfg_data > ONE) ? ONE : cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= d2aw_pkg::ST_IDLE;
            seg_reg    <= 16'd536;
            gain_reg   <= 17'd4096;
            alpha_reg  <= ONE;
            marked_reg <= '0;
            wb_reg     <= '0;
            wend_reg   <= '0;
            armed_reg  <= 1'b0;
            cnt_reg    <= '0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            seg_reg    <= seg_next;
            gain_reg   <= gain_next;
            alpha_reg  <= alpha_next;
            marked_reg <= marked_next;
            wb_reg     <= wb_next;
            wend_reg   <= wend_next;
            armed_reg  <= armed_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        segs_reg   <= segs_next;
        ece_reg    <= ece_next;
        ntx_reg    <= ntx_next;
        lack_reg   <= lack_next;
        txt_reg    <= txt_next;
        rtime_reg  <= rtime_next;
        rtt_reg    <= rtt_next;
        cwnd_reg   <= cwnd_next;
        prod_reg   <= prod_next;
        t1_reg     <= t1_next;
        frac_reg   <= frac_next;
        pen_reg    <= pen_next;
        closed_reg <= closed_next;
        ncwnd_reg  <= ncwnd_next;
        acc_reg    <= acc_next;
        mc_reg     <= mc_next;
        mp_reg     <= mp_next;
        den_reg    <= den_next;
        pq_reg     <= pq_next;
        y_reg      <= y_next;
        lfrac_reg  <= lfrac_next;
        m_reg      <= m_next;
        f_reg      <= f_next;
        r_reg      <= r_next;
        nsh_reg    <= nsh_next;
        big_reg    <= big_next;
    end

    assign m_alpha         = alpha_reg;
    assign m_window_closed = closed_reg;
    assign m_new_cwnd      = ncwnd_reg;

endmodule

>>> tb/sv/tb_d2tcp_alpha_window_update_top.sv
module tb_d2tcp_alpha_window_update_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int PHASES = 6;
    localparam int RAND_PER_PHASE = 134;
    localparam logic [63:0] ONE64 = 64'd1 << d2aw_pkg::FRAC_BITS;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    typedef enum logic {EV_ACK = 1'b0, EV_REDUCE = 1'b1} event_kind_t;

    typedef struct packed {
        event_kind_t kind;
        logic [15:0] segs;
        logic        ece;
        logic [31:0] next_tx;
        logic [31:0] acked;
        logic [31:0] tx_total;
        logic [47:0] remain;
        logic [47:0] rtt;
        logic [31:0] cwnd;
    } ack_event_t;

    typedef struct packed {
        logic [16:0] alpha;
        logic        closed;
        logic [31:0] new_cwnd;
    } window_result_t;

    typedef struct packed {
        ack_event_t     ev;
        logic           typed;
        window_result_t res;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = 1'b0;
    logic [15:0]        s_segments_acked = '0;
    logic               s_ece_received = 1'b0;
    logic [31:0]        s_next_tx_seq = '0;
    logic [31:0]        s_last_acked_seq = '0;
    logic [31:0]        s_tx_total = '0;
    logic signed [47:0] s_remain_time = '0;
    logic [47:0]        s_last_rtt = '0;
    logic [31:0]        s_cwnd = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [16:0]        m_alpha;
    logic               m_window_closed;
    logic [31:0]        m_new_cwnd;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [16:0]        cfg_data = '0;

    logic [15:0] seg_size_q;
    logic [16:0] gain_q;
    logic [16:0] alpha_q;
    logic [31:0] marked_q;
    logic [31:0] window_q;
    logic [31:0] end_seq_q;
    logic        armed_q;
    logic [63:0] exp_coef [d2aw_pkg::EXP_STEPS];

    window_result_t results_due[$];
    dir_row_t       dir_tab[$];
    int             errors = 0;
    int             idle_cycles = 0;
    bit             burst_mode = 1'b0;
    bit             hold_req = 1'b0;
    logic [31:0]    last_next_tx = '0;

    d2tcp_alpha_window_update_top u_top (.*);

    always #5 aclk = ~aclk;

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [63:0] deadline_power(input logic [63:0] a, input logic [63:0] pq);
        int          m;
        logic [63:0] y, frac, lq, r, n, f, s;
        logic [127:0] e;
        m = 0;
        frac = '0;
        r = Q30;
        if (a >= ONE64) return ONE64;
        if (a == 0) return (pq == 0) ? ONE64 : 64'd0;
        while ((a >> (m + 1)) != 0) m++;
        y = a << (30 - m);
        for (int i = 29; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (Q30 << 1)) begin
                y = y >> 1;
                frac[i] = 1'b1;
            end
        end
        lq = (64'(d2aw_pkg::FRAC_BITS - m) << 30) - frac;
        e = 128'(pq) * 128'(lq);
        n = 64'(e >> 62);
        f = 64'(e[61:32]);
        for (int i = 29; i >= 0; i--) begin
            if (f[i]) r = (r * exp_coef[29 - i]) >> 30;
        end
        if (n > 63) return 64'd0;
        s = 30 + n - d2aw_pkg::FRAC_BITS;
        return (s > 63) ? 64'd0 : (r >> s);
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [63:0] b);
        logic [63:0] t;
        t = 64'(a) + b;
        return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic window_result_t d2tcp_predict(input ack_event_t ev);
        window_result_t res;
        logic [63:0]  val, bytes, g, frac, rem, cw, pq, al;
        logic [127:0] num, den, q;
        res.closed = 1'b0;
        res.new_cwnd = ev.cwnd;
        if (ev.kind == EV_REDUCE) begin
            val = (64'(ev.cwnd) * ((ONE64 << 1) - 64'(alpha_q)))
                  >> (d2aw_pkg::FRAC_BITS + 1);
            res.new_cwnd = (val > 64'(seg_size_q)) ? val[31:0] : 32'(seg_size_q);
        end else begin
            bytes = 64'(ev.segs) * 64'(seg_size_q);
            window_q = sat_add32(window_q, bytes);
            if (ev.ece) marked_q = sat_add32(marked_q, bytes);
            if (!armed_q) begin
                end_seq_q = ev.next_tx;
                armed_q = 1'b1;
            end
            if (!(ev.acked - end_seq_q >= 32'h8000_0000)) begin
                g = (64'(gain_q) > ONE64) ? ONE64 : 64'(gain_q);
                frac = '0;
                if (window_q != 0) begin
                    frac = (64'(marked_q) << d2aw_pkg::FRAC_BITS) / 64'(window_q);
                    if (frac > ONE64) frac = ONE64;
                end
                al = ((ONE64 - g) * 64'(alpha_q) + g * frac + (ONE64 >> 1))
                     >> d2aw_pkg::FRAC_BITS;
                if (ev.remain != 0 && !ev.remain[47] && ev.tx_total != 0 && ev.rtt != 0) begin
                    rem = (ev.tx_total > window_q) ? 64'(ev.tx_total - window_q) : 64'd0;
                    cw = (ev.cwnd == 0) ? 64'd1 : 64'(ev.cwnd);
                    num = (128'(rem << 2) * 128'(ev.rtt)) << 32;
                    den = 128'(cw * 3) * 128'(ev.remain);
                    q = num / den;
                    pq = (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
                    al = deadline_power(al, pq);
                end
                alpha_q = al[16:0];
                marked_q = '0;
                window_q = '0;
                end_seq_q = ev.next_tx;
                res.closed = 1'b1;
            end
        end
        res.alpha = alpha_q;
        return res;
    endfunction

    function automatic ack_event_t make_event(input event_kind_t k, input logic [15:0] sg,
                                              input logic ec, input logic [31:0] nx,
                                              input logic [31:0] ak, input logic [31:0] tx,
                                              input logic [47:0] rt, input logic [47:0] rtt,
                                              input logic [31:0] cw);
        ack_event_t ev;
        ev.kind = k;
        ev.segs = sg;
        ev.ece = ec;
        ev.next_tx = nx;
        ev.acked = ak;
        ev.tx_total = tx;
        ev.remain = rt;
        ev.rtt = rtt;
        ev.cwnd = cw;
        return ev;
    endfunction

    function automatic void add_row(input ack_event_t ev, input logic typed,
                                    input logic [16:0] a, input logic c, input logic [31:0] nc);
        dir_row_t row;
        row.ev = ev;
        row.typed = typed;
        row.res.alpha = a;
        row.res.closed = c;
        row.res.new_cwnd = nc;
        dir_tab.push_back(row);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic ack_event_t random_event();
        ack_event_t ev;
        ev.kind = ($urandom_range(0, 9) < 2) ? EV_REDUCE : EV_ACK;
        ev.segs = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        ev.ece = 1'($urandom);
        if ($urandom_range(0, 9) < 7)
            ev.acked = last_next_tx + 32'($urandom_range(0, 400)) - 32'd200;
        else
            ev.acked = $urandom;
        ev.next_tx = ($urandom_range(0, 19) == 0) ? $urandom
                                                  : ev.acked + 32'($urandom_range(0, 3000));
        case ($urandom_range(0, 3))
            0: ev.tx_total = 0;
            1: ev.tx_total = 32'($urandom_range(1, 100000));
            default: ev.tx_total = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: ev.remain = '0;
            1: ev.remain = rand48() | 48'h8000_0000_0000;
            2: ev.remain = 48'($urandom_range(1, 1000000));
            3: ev.remain = 48'($urandom) * 48'd1000;
            default: ev.remain = rand48() & 48'h7FFF_FFFF_FFFF;
        endcase
        case ($urandom_range(0, 4))
            0: ev.rtt = '0;
            1: ev.rtt = rand48();
            default: ev.rtt = 48'($urandom_range(1, 2000000));
        endcase
        case ($urandom_range(0, 9))
            0: ev.cwnd = 0;
            1, 2, 3: ev.cwnd = $urandom;
            default: ev.cwnd = 32'($urandom_range(1, 200000));
        endcase
        last_next_tx = ev.next_tx;
        return ev;
    endfunction

    task automatic send_event(input ack_event_t ev, input logic typed, input window_result_t res);
        int gap;
        window_result_t pred;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= ev.kind;
        s_segments_acked <= ev.segs;
        s_ece_received <= ev.ece;
        s_next_tx_seq <= ev.next_tx;
        s_last_acked_seq <= ev.acked;
        s_tx_total <= ev.tx_total;
        s_remain_time <= ev.remain;
        s_last_rtt <= ev.rtt;
        s_cwnd <= ev.cwnd;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = d2tcp_predict(ev);
        results_due.push_back(typed ? res : pred);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            d2aw_pkg::CFG_SEGMENT_SIZE: seg_size_q = val[15:0];
            d2aw_pkg::CFG_GAIN_G: gain_q = val;
            d2aw_pkg::CFG_ALPHA_INIT: alpha_q = (64'(val) > ONE64) ? d2aw_pkg::ONE_Q : val;
            default: ;
        endcase
    endtask

    always begin
        int stall;
        window_result_t want;
        stall = burst_mode ? 0 : $urandom_range(0, 10);
        if (hold_req) begin
            stall = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (stall > 0) begin
            m_ready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (m_valid !== 1'b1);
        if (results_due.size() == 0) begin
            $display("%0t: unexpected transfer alpha=%0d closed=%0d new_cwnd=%0d",
                     $time, m_alpha, m_window_closed, m_new_cwnd);
            errors++;
        end else begin
            want = results_due.pop_front();
            if (m_alpha !== want.alpha) begin
                $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, m_alpha);
                errors++;
            end
            if (m_window_closed !== want.closed) begin
                $display("%0t: window_closed expected %0d actual %0d",
                         $time, want.closed, m_window_closed);
                errors++;
            end
            if (m_new_cwnd !== want.new_cwnd) begin
                $display("%0t: new_cwnd expected %0d actual %0d",
                         $time, want.new_cwnd, m_new_cwnd);
                errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [15:0] seg_tab [PHASES] = '{16'd536, 16'd1, 16'd65535, 16'd1460, 16'd9000, 16'd200};
        logic [16:0] gain_tab [PHASES] = '{17'd4096, 17'd0, 17'd65536, 17'h1FFFF, 17'd30000, 17'd1};
        logic [16:0] init_tab [PHASES] = '{17'd65536, 17'd0, 17'h1FFFF, 17'd30000, 17'd1, 17'd40000};
        logic [63:0] c;
        window_result_t none;

        none = '0;
        c = 64'd1 << 29;
        for (int i = 0; i < d2aw_pkg::EXP_STEPS; i++) begin
            exp_coef[i] = c;
            c = sqrt_floor(c << 30);
        end
        seg_size_q = 16'd536;
        gain_q = 17'd4096;
        alpha_q = d2aw_pkg::ONE_Q;
        marked_q = '0;
        window_q = '0;
        end_seq_q = '0;
        armed_q = 1'b0;

        add_row(make_event(EV_REDUCE, 0, 0, 0, 0, 0, 0, 0, 32'd1000), 1, 17'd65536, 0, 32'd536);
        add_row(make_event(EV_REDUCE, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, 17'd65536, 0,
                32'h7FFF_FFFF);
        add_row(make_event(EV_ACK, 0, 0, 32'd1000, 32'd500, 0, 0, 0, 32'd7), 1, 17'd65536, 0,
                32'd7);
        add_row(make_event(EV_ACK, 16'hFFFF, 1, 32'd2000, 32'd999, 32'hFFFF_FFFF, 0, 0, 32'd1),
                0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd10, 0, 32'd3000, 32'd1000, 32'd5000, 0, 48'd500,
                32'd9000), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd20, 1, 32'd4000, 32'd3000, 32'd50000,
                48'h8000_0000_0000, 48'd500, 32'd9000), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd5, 1, 32'd5000, 32'd4000, 32'd50000, 48'd1000000000,
                48'd0, 32'd9000), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd5, 1, 32'd6000, 32'd5000, 32'd0, 48'd1000000000,
                48'd7000, 32'd9000), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd3, 1, 32'd7000, 32'd6000, 32'd1000000, 48'd1000000,
                48'd100000, 32'd0), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd4, 0, 32'd8000, 32'd7000, 32'hFFFF_FFFF,
                48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd2, 1, 32'hFFFF_FF00, 32'd8000, 32'hFFFF_FFFF, 48'd1,
                48'hFFFF_FFFF_FFFF, 32'd1), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd1, 0, 32'h0000_0100, 32'h0000_0005, 32'd300000,
                48'd2000000, 48'd80000, 32'd15000), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'hFFFF, 1, 32'h0000_0200, 32'h0000_0100, 32'd1,
                48'd2000000, 48'd80000, 32'd15000), 0, 0, 0, 0);
        add_row(make_event(EV_ACK, 16'd7, 1, 32'h0000_0300, 32'h0000_0150, 32'd1000,
                48'd2000, 48'd100, 32'd1500), 0, 0, 0, 0);
        add_row(make_event(EV_REDUCE, 0, 0, 0, 0, 0, 0, 0, 32'd123456), 0, 0, 0, 0);
        add_row(make_event(EV_REDUCE, 0, 0, 0, 0, 0, 0, 0, 32'd0), 0, 0, 0, 0);
        last_next_tx = 32'h0000_0300;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].res);
        drain();
        write_reg(CFG_UNUSED, 17'h1FFFF);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                write_reg(d2aw_pkg::CFG_SEGMENT_SIZE, 17'(seg_tab[p]));
                write_reg(d2aw_pkg::CFG_GAIN_G, gain_tab[p]);
                write_reg(d2aw_pkg::CFG_ALPHA_INIT, init_tab[p]);
            end
            burst_mode = (p == 2 || p == 4);
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if (p == 1 && i == 40) hold_req = 1'b1;
                send_event(random_event(), 1'b0, none);
            end
            drain();
        end
        burst_mode = 1'b0;

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
